[src/mpss_pkg.sv]
// Package for the mouse-pan to stick smoother.
// Holds the sequencer state type, command codes and fixed-point constants.
// No dependencies.
package mpss_pkg;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Q14 fixed-point constants; GAIN_Q24 is in Q24
  localparam int unsigned Q14_ONE  = 16384;
  localparam int unsigned Q14_HALF = 8192;
  localparam int unsigned W_OLD    = 5079;
  localparam int unsigned W_NEW    = 11305;
  localparam int unsigned DECAY    = 12452;
  localparam int unsigned GAIN_Q24 = 73820;
  localparam int unsigned CLAMP    = 10 * Q14_ONE;

  localparam int AVG_W    = 20;
  localparam int IDLE_W   = 5;
  localparam int IDLE_MAX = 31;
  localparam int SENS_W   = 16;
  localparam int STICK_W  = 16;
  localparam int SENS_RST = 256;

  // Shared arithmetic unit widths
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int SQ_VW  = 64;
  localparam int SQ_RW  = 32;
  localparam int CNT_W  = 6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MSQX, ST_MSQY, ST_SQS,
    ST_DIVMX, ST_DIVMY,
    ST_MIXAX, ST_MIXMX, ST_MIXAY, ST_MIXMY,
    ST_LSQX, ST_LSQY, ST_SQL,
    ST_CLX, ST_CDX, ST_CLY, ST_CDY,
    ST_UDX, ST_UDY, ST_WB,
    ST_DECX, ST_DECY,
    ST_STX1, ST_STX2, ST_STY1, ST_STY2,
    ST_TCNT, ST_FIN
  } state_t;

  // Round (p + 2^30) >> 31 and saturate to signed Q1.15
  function automatic logic signed [STICK_W-1:0] stick_sat(input logic neg,
                                                          input logic [63:0] p);
    logic [63:0] q;
    logic signed [STICK_W-1:0] r;
    q = (p + 64'd1073741824) >> 31;
    if (neg) begin
      if (q > 64'd32768) r = 16'sh8000;
      else r = STICK_W'(-q);
    end else begin
      if (q > 64'd32767) r = 16'sh7FFF;
      else r = STICK_W'(q);
    end
    return r;
  endfunction

endpackage

[src/mpss_ifs.sv]
// Channel interfaces of the mouse-pan to stick smoother: input, result, config.
// Each carries valid, ready and its payload. No dependencies.
interface mpss_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] anchor_x;
  logic [COORD_BITS-1:0] anchor_y;
  logic                  panning;
  modport source (output valid, command, pos_x, pos_y, anchor_x, anchor_y, panning,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, anchor_x, anchor_y, panning,
                output ready);
endinterface

interface mpss_out_if;
  logic               valid;
  logic               ready;
  logic               stick_valid;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic               pan_stopped;
  modport source (output valid, stick_valid, stick_x, stick_y, pan_stopped,
                  input ready);
  modport sink (input valid, stick_valid, stick_x, stick_y, pan_stopped,
                output ready);
endinterface

interface mpss_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/mouse_pan_to_stick_smoother_top.sv]
// Mouse-pan to stick smoother, top level.
// Depends on mpss_pkg and the channel interfaces in mpss_ifs.sv.
//
// Usage:
//   in_chan carries one item: a move (command 0) with pointer and centre
//   coordinates, or a tick (command 1) with the panning flag. Each item gives
//   exactly one result item on out_chan. cfg_chan writes the Q8.8 sensitivity
//   and is always ready; write it only while the block is idle.
// Processing:
//   The block works on one item at a time through a shared bit-serial
//   multiplier (one multiplier bit per cycle, stops early when the remaining
//   bits are zero), a 48-step restoring divider and a 32-step square root.
//   The sequencer goes back to idle, ready for the next item, when the result
//   is loaded.
// Reset:
//   rst_n low at a clock edge clears the average, the idle counter and any
//   pending result, and sets the sensitivity to 1.0.
// Stall:
//   A finished result waits in the output register; the next item may be
//   taken meanwhile, but a second result holds the sequencer until the
//   first has been taken.
module mouse_pan_to_stick_smoother_top
  import mpss_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int IDLE_LIMIT = 15
) (
  input logic          clk,
  input logic          rst_n,
  mpss_cfg_if.sink     cfg_chan,
  mpss_in_if.sink      in_chan,
  mpss_out_if.source   out_chan
);

  localparam int CW  = COORD_BITS;
  localparam int M2W = 2 * CW + 2;
  localparam int MXW = CW + 15;
  localparam int SW  = MXW + 15;
  localparam int NW  = CW + 16;

  state_t state_r, state_nxt;

  logic [SENS_W-1:0]        sens_r;
  logic signed [CW:0]       dx_r, dy_r;
  logic [M2W-1:0]           m2_r;
  logic [SQ_RW-1:0]         s_r;
  logic signed [MXW-1:0]    mx_r, my_r;
  logic signed [SW-1:0]     acc_r;
  logic signed [NW-1:0]     nx_r, ny_r;
  logic [63:0]              l2_r;
  logic signed [AVG_W-1:0]  avg_x_r, avg_y_r;
  logic [IDLE_W-1:0]        idle_r;
  logic                     res_sv_r, res_ps_r;
  logic signed [STICK_W-1:0] res_sx_r, res_sy_r;
  logic                     out_valid_r;
  logic                     out_sv_r, out_ps_r;
  logic signed [STICK_W-1:0] out_sx_r, out_sy_r;

  // shared units
  logic [MUL_AW-1:0] mul_a_r, mul_p_r;
  logic [MUL_BW-1:0] mul_b_r;
  logic [DIV_NW-1:0] div_n_r, div_q_r;
  logic [DIV_DW-1:0] div_d_r, div_rem_r;
  logic [CNT_W-1:0]  div_cnt_r;
  logic [SQ_VW-1:0]  sq_v_r;
  logic [SQ_RW+1:0]  sq_rem_r;
  logic [SQ_RW-1:0]  sq_root_r;
  logic [CNT_W-1:0]  sq_cnt_r;

  logic              mul_ld, div_ld, sq_ld;
  logic [MUL_AW-1:0] mul_a_in;
  logic [MUL_BW-1:0] mul_b_in;
  logic [DIV_NW-1:0] div_n_in;
  logic [DIV_DW-1:0] div_d_in;
  logic [SQ_VW-1:0]  sq_v_in;

  logic mul_done, div_done, sq_done, in_fire, out_free, ld;

  logic signed [CW:0] in_dx, in_dy;
  logic [CW:0]        in_dx_mag;
  logic [CW:0]        dx_mag, dy_mag;
  logic [MXW-1:0]     mx_mag, my_mag;
  logic [NW-1:0]      nx_mag, ny_mag;
  logic [AVG_W-1:0]   avg_x_mag, avg_y_mag;
  logic [M2W-1:0]     m2_sum;
  logic               mix_neg, dec_neg;
  logic signed [SW-1:0] mix_sum;
  logic [SW-1:0]      mix_mag, mix_q;
  logic signed [NW-1:0] mix_res;
  logic [63:0]        dec_q;
  logic signed [AVG_W-1:0] dec_res;
  logic signed [NW-1:0] div_pos, div_negv;

  assign mul_done = (mul_b_r == '0);
  assign div_done = (div_cnt_r == '0);
  assign sq_done  = (sq_cnt_r == '0);
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.stick_valid = out_sv_r;
  assign out_chan.stick_x     = out_sx_r;
  assign out_chan.stick_y     = out_sy_r;
  assign out_chan.pan_stopped = out_ps_r;

  // delta of the item being accepted, so the first square starts at once
  assign in_dx     = signed'({1'b0, in_chan.pos_x}) - signed'({1'b0, in_chan.anchor_x});
  assign in_dy     = signed'({1'b0, in_chan.pos_y}) - signed'({1'b0, in_chan.anchor_y});
  assign in_dx_mag = in_dx[CW] ? (CW+1)'(-in_dx) : (CW+1)'(in_dx);

  assign dx_mag    = dx_r[CW] ? (CW+1)'(-dx_r) : (CW+1)'(dx_r);
  assign dy_mag    = dy_r[CW] ? (CW+1)'(-dy_r) : (CW+1)'(dy_r);
  assign mx_mag    = mx_r[MXW-1] ? MXW'(-mx_r) : MXW'(mx_r);
  assign my_mag    = my_r[MXW-1] ? MXW'(-my_r) : MXW'(my_r);
  assign nx_mag    = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
  assign ny_mag    = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
  assign avg_x_mag = avg_x_r[AVG_W-1] ? AVG_W'(-avg_x_r) : AVG_W'(avg_x_r);
  assign avg_y_mag = avg_y_r[AVG_W-1] ? AVG_W'(-avg_y_r) : AVG_W'(avg_y_r);
  assign m2_sum    = m2_r + M2W'(mul_p_r);

  // mix: round (acc + signed product) / 2^14, ties away from zero
  assign mix_neg = (state_r == ST_MIXMX) ? mx_r[MXW-1] : my_r[MXW-1];
  assign mix_sum = acc_r + (mix_neg ? -SW'(mul_p_r) : SW'(mul_p_r));
  assign mix_mag = mix_sum[SW-1] ? SW'(-mix_sum) : SW'(mix_sum);
  assign mix_q   = (mix_mag + SW'(Q14_HALF)) >> 14;
  assign mix_res = mix_sum[SW-1] ? -NW'(mix_q) : NW'(mix_q);

  // decay rounding
  assign dec_neg = (state_r == ST_DECX) ? avg_x_r[AVG_W-1] : avg_y_r[AVG_W-1];
  assign dec_q   = (mul_p_r + 64'(Q14_HALF)) >> 14;
  assign dec_res = dec_neg ? -AVG_W'(dec_q) : AVG_W'(dec_q);

  assign div_pos  = NW'(div_q_r);
  assign div_negv = -NW'(div_q_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.command == CMD_TICK) state_nxt = in_chan.panning ? ST_DECX : ST_TCNT;
          else state_nxt = ST_MSQX;
        end
      end
      ST_MSQX:  if (mul_done) state_nxt = ST_MSQY;
      ST_MSQY:  if (mul_done) state_nxt = (m2_sum == '0) ? ST_FIN : ST_SQS;
      ST_SQS:   if (sq_done) state_nxt = (m2_r < M2W'(9)) ? ST_DIVMX : ST_MIXAX;
      ST_DIVMX: if (div_done) state_nxt = ST_DIVMY;
      ST_DIVMY: if (div_done) state_nxt = ST_MIXAX;
      ST_MIXAX: if (mul_done) state_nxt = ST_MIXMX;
      ST_MIXMX: if (mul_done) state_nxt = ST_MIXAY;
      ST_MIXAY: if (mul_done) state_nxt = ST_MIXMY;
      ST_MIXMY: if (mul_done) state_nxt = ST_LSQX;
      ST_LSQX:  if (mul_done) state_nxt = ST_LSQY;
      ST_LSQY:  if (mul_done) state_nxt = ST_SQL;
      ST_SQL: begin
        if (sq_done) begin
          if (sq_root_r > SQ_RW'(CLAMP)) state_nxt = ST_CLX;
          else if (sq_root_r < SQ_RW'(Q14_ONE)) state_nxt = ST_UDX;
          else state_nxt = ST_WB;
        end
      end
      ST_CLX:   if (mul_done) state_nxt = ST_CDX;
      ST_CDX:   if (div_done) state_nxt = ST_CLY;
      ST_CLY:   if (mul_done) state_nxt = ST_CDY;
      ST_CDY:   if (div_done) state_nxt = ST_WB;
      ST_UDX:   if (div_done) state_nxt = ST_UDY;
      ST_UDY:   if (div_done) state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_FIN;
      ST_DECX:  if (mul_done) state_nxt = ST_DECY;
      ST_DECY:  if (mul_done) state_nxt = ST_STX1;
      ST_STX1:  if (mul_done) state_nxt = ST_STX2;
      ST_STX2:  if (mul_done) state_nxt = ST_STY1;
      ST_STY1:  if (mul_done) state_nxt = ST_STY2;
      ST_STY2:  if (mul_done) state_nxt = ST_TCNT;
      ST_TCNT:  state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // unit loads on entry to a state
  always_comb begin
    ld       = (state_nxt != state_r);
    mul_ld   = 1'b0;
    div_ld   = 1'b0;
    sq_ld    = 1'b0;
    mul_a_in = '0;
    mul_b_in = '0;
    div_n_in = '0;
    div_d_in = '0;
    sq_v_in  = '0;
    unique case (state_nxt)
      ST_MSQX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(in_dx_mag); mul_b_in = MUL_BW'(in_dx_mag);
      end
      ST_MSQY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(dy_mag); mul_b_in = MUL_BW'(dy_mag);
      end
      ST_SQS: begin
        sq_ld = ld; sq_v_in = SQ_VW'(m2_sum) << 28;
      end
      ST_DIVMX: begin
        div_ld   = ld;
        div_n_in = ((DIV_NW'(dx_mag) + (DIV_NW'(dx_mag) << 1)) << 28)
                   + DIV_NW'(sq_root_r >> 1);
        div_d_in = sq_root_r;
      end
      ST_DIVMY: begin
        div_ld   = ld;
        div_n_in = ((DIV_NW'(dy_mag) + (DIV_NW'(dy_mag) << 1)) << 28)
                   + DIV_NW'(sq_root_r >> 1);
        div_d_in = sq_root_r;
      end
      ST_MIXAX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_x_mag); mul_b_in = MUL_BW'(W_OLD);
      end
      ST_MIXMX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(mx_mag); mul_b_in = MUL_BW'(W_NEW);
      end
      ST_MIXAY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_y_mag); mul_b_in = MUL_BW'(W_OLD);
      end
      ST_MIXMY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(my_mag); mul_b_in = MUL_BW'(W_NEW);
      end
      ST_LSQX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(nx_mag); mul_b_in = MUL_BW'(nx_mag);
      end
      ST_LSQY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(ny_mag); mul_b_in = MUL_BW'(ny_mag);
      end
      ST_SQL: begin
        sq_ld = ld; sq_v_in = l2_r + mul_p_r;
      end
      ST_CLX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(nx_mag); mul_b_in = MUL_BW'(CLAMP);
      end
      ST_CLY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(ny_mag); mul_b_in = MUL_BW'(CLAMP);
      end
      ST_CDX, ST_CDY: begin
        div_ld   = ld;
        div_n_in = DIV_NW'(mul_p_r) + DIV_NW'(sq_root_r >> 1);
        div_d_in = sq_root_r;
      end
      ST_UDX: begin
        div_ld   = ld;
        div_n_in = (DIV_NW'(dx_mag) << 28) + DIV_NW'(s_r >> 1);
        div_d_in = s_r;
      end
      ST_UDY: begin
        div_ld   = ld;
        div_n_in = (DIV_NW'(dy_mag) << 28) + DIV_NW'(s_r >> 1);
        div_d_in = s_r;
      end
      ST_DECX: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_x_mag); mul_b_in = MUL_BW'(DECAY);
      end
      ST_DECY: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_y_mag); mul_b_in = MUL_BW'(DECAY);
      end
      ST_STX1: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_x_mag); mul_b_in = MUL_BW'(sens_r);
      end
      ST_STY1: begin
        mul_ld = ld; mul_a_in = MUL_AW'(avg_y_mag); mul_b_in = MUL_BW'(sens_r);
      end
      ST_STX2, ST_STY2: begin
        mul_ld = ld; mul_a_in = mul_p_r; mul_b_in = MUL_BW'(GAIN_Q24);
      end
      default: begin
      end
    endcase
  end

  // bit-serial multiplier: one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_b_r <= '0;
    end else if (mul_ld) begin
      mul_a_r <= mul_a_in;
      mul_b_r <= mul_b_in;
      mul_p_r <= '0;
    end else if (!mul_done) begin
      if (mul_b_r[0]) mul_p_r <= mul_p_r + mul_a_r;
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  // restoring divider: one quotient bit a cycle
  logic [DIV_DW:0] div_trial;
  logic            div_ge;
  assign div_trial = {div_rem_r, div_n_r[DIV_NW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_ld) begin
      div_n_r   <= div_n_in;
      div_d_r   <= div_d_in;
      div_rem_r <= '0;
      div_q_r   <= '0;
      div_cnt_r <= CNT_W'(DIV_NW);
    end else if (!div_done) begin
      div_rem_r <= div_ge ? DIV_DW'(div_trial - {1'b0, div_d_r}) : DIV_DW'(div_trial);
      div_q_r   <= {div_q_r[DIV_NW-2:0], div_ge};
      div_n_r   <= div_n_r << 1;
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // floor square root: one root bit a cycle
  logic [SQ_RW+3:0] sq_cur, sq_trial;
  logic             sq_ge;
  assign sq_cur   = {sq_rem_r, sq_v_r[SQ_VW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_ld) begin
      sq_v_r    <= sq_v_in;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= CNT_W'(SQ_RW);
    end else if (!sq_done) begin
      sq_rem_r  <= sq_ge ? (SQ_RW+2)'(sq_cur - sq_trial) : (SQ_RW+2)'(sq_cur);
      sq_root_r <= {sq_root_r[SQ_RW-2:0], sq_ge};
      sq_v_r    <= sq_v_r << 2;
      sq_cnt_r  <= sq_cnt_r - 1'b1;
    end
  end

  // state, configuration and kept average
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sens_r      <= SENS_W'(SENS_RST);
      avg_x_r     <= '0;
      avg_y_r     <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) sens_r <= cfg_chan.data;
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;

      if (in_fire && in_chan.command == CMD_MOVE) idle_r <= '0;

      unique case (state_r)
        ST_DECX: if (mul_done) avg_x_r <= dec_res;
        ST_DECY: if (mul_done) avg_y_r <= dec_res;
        ST_WB: begin
          avg_x_r <= AVG_W'(nx_r);
          avg_y_r <= AVG_W'(ny_r);
        end
        ST_TCNT: begin
          if (idle_r < IDLE_W'(IDLE_MAX)) idle_r <= idle_r + 1'b1;
          // clear after the stick value has been computed
          if (idle_r > IDLE_W'(IDLE_LIMIT)) begin
            avg_x_r <= '0;
            avg_y_r <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          dx_r     <= in_dx;
          dy_r     <= in_dy;
          res_sv_r <= (in_chan.command == CMD_TICK) && in_chan.panning;
          res_sx_r <= '0;
          res_sy_r <= '0;
          res_ps_r <= 1'b0;
        end
      end
      ST_MSQX: if (mul_done) m2_r <= M2W'(mul_p_r);
      ST_MSQY: if (mul_done) m2_r <= m2_sum;
      ST_SQS: begin
        if (sq_done) begin
          s_r  <= sq_root_r;
          mx_r <= MXW'(dx_r) <<< 14;
          my_r <= MXW'(dy_r) <<< 14;
        end
      end
      ST_DIVMX: if (div_done) mx_r <= dx_r[CW] ? -MXW'(div_q_r) : MXW'(div_q_r);
      ST_DIVMY: if (div_done) my_r <= dy_r[CW] ? -MXW'(div_q_r) : MXW'(div_q_r);
      ST_MIXAX: begin
        if (mul_done) acc_r <= avg_x_r[AVG_W-1] ? -SW'(mul_p_r) : SW'(mul_p_r);
      end
      ST_MIXAY: begin
        if (mul_done) acc_r <= avg_y_r[AVG_W-1] ? -SW'(mul_p_r) : SW'(mul_p_r);
      end
      ST_MIXMX: if (mul_done) nx_r <= mix_res;
      ST_MIXMY: if (mul_done) ny_r <= mix_res;
      ST_LSQX:  if (mul_done) l2_r <= mul_p_r;
      ST_CDX:   if (div_done) nx_r <= nx_r[NW-1] ? div_negv : div_pos;
      ST_CDY:   if (div_done) ny_r <= ny_r[NW-1] ? div_negv : div_pos;
      ST_UDX:   if (div_done) nx_r <= dx_r[CW] ? div_negv : div_pos;
      ST_UDY:   if (div_done) ny_r <= dy_r[CW] ? div_negv : div_pos;
      ST_STX2:  if (mul_done) res_sx_r <= stick_sat(avg_x_r[AVG_W-1], mul_p_r);
      ST_STY2:  if (mul_done) res_sy_r <= stick_sat(avg_y_r[AVG_W-1], mul_p_r);
      ST_TCNT:  res_ps_r <= (idle_r > IDLE_W'(IDLE_LIMIT));
      ST_FIN: begin
        if (out_free) begin
          out_sv_r <= res_sv_r;
          out_sx_r <= res_sx_r;
          out_sy_r <= res_sy_r;
          out_ps_r <= res_ps_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after taking an item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> out_valid_r)
    else $error("finished item not presented on the result channel");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TCNT && idle_r > IDLE_W'(IDLE_LIMIT))
      |=> (avg_x_r == '0 && avg_y_r == '0 && res_ps_r))
    else $error("idle timeout did not clear the average");

  a_move_no_stick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |-> (!res_sv_r && res_sx_r == '0 && res_sy_r == '0))
    else $error("move item carries a stick value");

  a_clamp_branch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLX |-> sq_root_r > SQ_RW'(CLAMP))
    else $error("clamp taken with an average length inside the limit");

endmodule

[test/tb_stick_channels.sv]
`timescale 1ns / 100ps
// Test-side view of the smoother's channels: nothing beyond the interfaces in mpss_ifs.sv.
// Imports mpss_pkg; no other dependencies.
package tb_stick_pkg;
  import mpss_pkg::*;

  typedef struct {
    logic        command;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] anchor_x;
    logic [11:0] anchor_y;
    logic        panning;
  } pointer_item_t;

  typedef struct {
    logic               stick_valid;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic               pan_stopped;
  } stick_item_t;
endpackage

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for mouse_pan_to_stick_smoother_top: directed and random moves and ticks,
// each result checked against an in-bench fixed-point predictor of the smoothing.
// Depends on mpss_pkg, mpss_ifs.sv and tb_stick_pkg.
module tb_top;
  import mpss_pkg::*;
  import tb_stick_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mpss_cfg_if cfg_chan ();
  mpss_in_if #(.COORD_BITS(12)) in_chan ();
  mpss_out_if out_chan ();

  mouse_pan_to_stick_smoother_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_chan(cfg_chan), .in_chan(in_chan), .out_chan(out_chan)
  );

  pointer_item_t pending_moves[$];
  stick_item_t   expected_sticks[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_sender = 0;
  bit quiet_receiver = 0;

  // Smoother state copy
  longint sm_ax, sm_ay;
  int     sm_idle;
  longint sm_sens;

  function automatic longint round_div(longint num, longint den);
    longint q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] stick_of_avg(longint a);
    longint unsigned p, q;
    p = longint'(a < 0 ? -a : a) * sm_sens * 73820;
    q = (p + (64'd1 << 30)) >> 31;
    if (a < 0) return q > 32768 ? 16'sh8000 : 16'(-longint'(q));
    return q > 32767 ? 16'sh7FFF : 16'(q);
  endfunction

  function automatic stick_item_t smooth_step(pointer_item_t it);
    stick_item_t r;
    longint dx, dy, m2, s, mx, my, nx, ny, len;
    bit stop;
    r = '{1'b0, 16'sd0, 16'sd0, 1'b0};
    if (it.command == CMD_MOVE) begin
      dx = longint'(it.pos_x) - longint'(it.anchor_x);
      dy = longint'(it.pos_y) - longint'(it.anchor_y);
      m2 = dx * dx + dy * dy;
      sm_idle = 0;
      if (m2 == 0) return r;
      s = floor_sqrt(m2 << 28);
      if (m2 < 9) begin
        mx = round_div(dx * 3 * (64'sd1 << 28), s);
        my = round_div(dy * 3 * (64'sd1 << 28), s);
      end else begin
        mx = dx * Q14_ONE;
        my = dy * Q14_ONE;
      end
      nx = round_div(sm_ax * W_OLD + mx * W_NEW, Q14_ONE);
      ny = round_div(sm_ay * W_OLD + my * W_NEW, Q14_ONE);
      len = floor_sqrt(nx * nx + ny * ny);
      if (len > 10 * Q14_ONE) begin
        nx = round_div(nx * 10 * Q14_ONE, len);
        ny = round_div(ny * 10 * Q14_ONE, len);
      end else if (len < Q14_ONE) begin
        nx = round_div(dx * (64'sd1 << 28), s);
        ny = round_div(dy * (64'sd1 << 28), s);
      end
      sm_ax = nx;
      sm_ay = ny;
      return r;
    end
    if (it.panning) begin
      sm_ax = round_div(sm_ax * DECAY, Q14_ONE);
      sm_ay = round_div(sm_ay * DECAY, Q14_ONE);
      r.stick_valid = 1'b1;
      r.stick_x = stick_of_avg(sm_ax);
      r.stick_y = stick_of_avg(sm_ay);
    end
    stop = sm_idle > 15;
    if (sm_idle < IDLE_MAX) sm_idle++;
    if (stop) begin
      sm_ax = 0;
      sm_ay = 0;
      r.pan_stopped = 1'b1;
    end
    return r;
  endfunction

  // Driver: hold an item until taken, idle now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid    <= 1'b0;
      in_chan.command  <= CMD_MOVE;
      in_chan.pos_x    <= '0;
      in_chan.pos_y    <= '0;
      in_chan.anchor_x <= '0;
      in_chan.anchor_y <= '0;
      in_chan.panning  <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) expected_sticks.push_back(smooth_step(pending_moves[0]));
      if (in_chan.valid) void'(pending_moves.pop_front());
      if (pending_moves.size() > 0 && (quiet_sender || $urandom_range(99) >= 8)) begin
        in_chan.valid    <= 1'b1;
        in_chan.command  <= pending_moves[0].command;
        in_chan.pos_x    <= pending_moves[0].pos_x;
        in_chan.pos_y    <= pending_moves[0].pos_y;
        in_chan.anchor_x <= pending_moves[0].anchor_x;
        in_chan.anchor_y <= pending_moves[0].anchor_y;
        in_chan.panning  <= pending_moves[0].panning;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Monitor: take results and compare with the oldest prediction
  always @(posedge clk) begin
    stick_item_t want;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_sticks.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          want = expected_sticks.pop_front();
          if (out_chan.stick_valid !== want.stick_valid) begin
            $error("stick_valid: expected %0d got %0d", want.stick_valid, out_chan.stick_valid);
            errors++;
          end
          if (out_chan.stick_x !== want.stick_x) begin
            $error("stick_x: expected %0d got %0d", want.stick_x, out_chan.stick_x);
            errors++;
          end
          if (out_chan.stick_y !== want.stick_y) begin
            $error("stick_y: expected %0d got %0d", want.stick_y, out_chan.stick_y);
            errors++;
          end
          if (out_chan.pan_stopped !== want.pan_stopped) begin
            $error("pan_stopped: expected %0d got %0d", want.pan_stopped, out_chan.pan_stopped);
            errors++;
          end
        end
      end
      out_chan.ready <= quiet_receiver || $urandom_range(99) >= 8;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_move(int px, int py, int cx, int cy);
    pending_moves.push_back('{CMD_MOVE, 12'(px), 12'(py), 12'(cx), 12'(cy), 1'b0});
  endtask

  task automatic add_tick(bit pan);
    pending_moves.push_back('{CMD_TICK, 12'($urandom), 12'($urandom), 12'($urandom),
                              12'($urandom), pan});
  endtask

  task automatic drain_block();
    while (pending_moves.size() > 0 || in_chan.valid || expected_sticks.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_sensitivity(logic [15:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    sm_sens = v;
  endtask

  // Mostly short drags around a centre, then runs of panning ticks
  task automatic add_random_burst();
    int cx, cy, span;
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    span = ($urandom_range(3) == 0) ? 4095 : ($urandom_range(1) ? 3 : 40);
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(9) == 0) add_tick($urandom_range(1));
      else add_move($urandom_range(4095) % 4096 * (span == 4095) +
                    (span != 4095) * ((cx + $urandom_range(2 * span) - span) & 12'hFFF),
                    $urandom_range(4095) % 4096 * (span == 4095) +
                    (span != 4095) * ((cy + $urandom_range(2 * span) - span) & 12'hFFF),
                    cx, cy);
    end
    repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 22 : 6))
      add_tick($urandom_range(9) != 0);
  endtask

  initial begin
    logic [15:0] sens_steps[4];
    sens_steps = '{16'hFFFF, 16'h0000, 16'h0100, 16'(0)};
    sm_ax = 0;
    sm_ay = 0;
    sm_idle = 0;
    sm_sens = SENS_RST;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero delta, short deltas, clamp, idle timeout
    add_tick(1'b1);
    add_move(2048, 2048, 2048, 2048);
    add_move(2049, 2048, 2048, 2048);
    add_tick(1'b1);
    add_move(2047, 2047, 2048, 2048);
    add_move(4095, 4095, 0, 0);
    add_tick(1'b1);
    add_move(0, 0, 4095, 4095);
    add_move(0, 4095, 4095, 0);
    add_tick(1'b0);
    add_move(2050, 2049, 2048, 2048);
    add_tick(1'b1);
    repeat (18) add_tick(1'b1);
    drain_block();

    // Saturate at maximum sensitivity
    write_sensitivity(16'hFFFF);
    add_move(4095, 0, 0, 4095);
    add_move(4095, 0, 0, 4095);
    add_tick(1'b1);
    add_move(0, 4095, 4095, 0);
    add_tick(1'b1);
    drain_block();

    for (int ph = 0; ph < 4; ph++) begin
      sens_steps[3] = 16'($urandom);
      write_sensitivity(sens_steps[ph]);
      quiet_sender = (ph == 2);
      quiet_receiver = (ph == 2);
      while (pending_moves.size() < 105) add_random_burst();
      // In phase 1, drain the block fully, then queue a second batch of bursts
      if (ph == 1) begin
        drain_block();
        while (pending_moves.size() < 30) add_random_burst();
      end
      drain_block();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
